FILE: src/checked_add_sub_mul_overflow_unit_macros.svh
// ----------------------------------------------------------------------------
// Checked arithmetic unit: assertion macros
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef CHECKED_ADD_SUB_MUL_OVERFLOW_UNIT_MACROS_SVH
`define CHECKED_ADD_SUB_MUL_OVERFLOW_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define CKD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define CKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ckd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked arithmetic unit: package
// Opcodes, target width codes and the payloads passed between stages.
// ----------------------------------------------------------------------------
package ckd_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_NOP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    WC_8  = 2'd0,
    WC_16 = 2'd1,
    WC_32 = 2'd2,
    WC_64 = 2'd3
  } wcode_e;

  // Operands in sign-magnitude form; right sign already flipped for subtract.
  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] a_mag;
    logic             a_neg;
    logic [DataW-1:0] b_mag;
    logic             b_neg;
    wcode_e           wcode;
    logic             tsig;
  } smop_t;

  // Sign-magnitude sum plus the four 32x32 partial products.
  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] sum_mag;
    logic             sum_big;
    logic             sum_neg;
    logic [DataW-1:0] pp_ll;
    logic [DataW-1:0] pp_lh;
    logic [DataW-1:0] pp_hl;
    logic [DataW-1:0] pp_hh;
    logic             prod_neg;
    wcode_e           wcode;
    logic             tsig;
  } part_t;

  // Exact result: low 64 magnitude bits, wider-than-64 flag, sign.
  typedef struct packed {
    logic             nop;
    logic [DataW-1:0] mag;
    logic             big;
    logic             neg;
    wcode_e           wcode;
    logic             tsig;
  } res_t;

endpackage

FILE: src/checked_add_sub_mul_overflow_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked add / subtract / multiply unit
// Exact integer arithmetic with wrap to a target type and an overflow flag.
// ----------------------------------------------------------------------------
// Each item names an operation (add, left minus right, multiply), two 64-bit
// operands each tagged signed or unsigned, and a target type of 8, 16, 32 or
// 64 bits, signed or unsigned. The unit forms the exact result, returns its
// low target-width bits in two's complement (upper bits zero) and sets
// overflowed when the exact value does not fit the target; the unused opcode
// returns zero with no overflow. The unit takes one item every clock while
// the output is not stalled and passes each item through four registered
// stages: an input stage converts operands to sign-magnitude form,
// an arithmetic stage does the 65-bit add/subtract and four 32x32 partial
// products, a merge stage sums the products into a 128-bit magnitude, and an
// output stage wraps and checks the range. The depth is set by that split
// of the 64x64 multiply. Every stage holds one item; a stall at the output
// backs up stage by stage, so in_stall_o rises only once all four stages are
// full.
`include "checked_add_sub_mul_overflow_unit_macros.svh"

module checked_add_sub_mul_overflow_unit import ckd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input items
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       opcode_i,
  input  logic [DataW-1:0] left_bits_i,
  input  logic             left_signed_i,
  input  logic [DataW-1:0] right_bits_i,
  input  logic             right_signed_i,
  input  logic [1:0]       target_width_code_i,
  input  logic             target_signed_i,
  // result items
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] stored_bits_o,
  output logic             overflowed_o
);

  logic  front_ready;
  logic  front_valid;
  smop_t front_op;
  logic  arith_ready;
  logic  arith_valid;
  part_t arith_part;
  logic  merge_ready;
  logic  merge_valid;
  res_t  merge_res;
  logic  pack_ready;

  // stage 1: sign-magnitude operands
  ckd_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (in_valid_i),
    .ready_o            (front_ready),
    .opcode_i           (opcode_i),
    .left_bits_i        (left_bits_i),
    .left_signed_i      (left_signed_i),
    .right_bits_i       (right_bits_i),
    .right_signed_i     (right_signed_i),
    .target_width_code_i(target_width_code_i),
    .target_signed_i    (target_signed_i),
    .valid_o            (front_valid),
    .ready_i            (arith_ready),
    .op_o               (front_op)
  );

  // stage 2: add/subtract and partial products
  ckd_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(front_valid),
    .ready_o(arith_ready),
    .op_i   (front_op),
    .valid_o(arith_valid),
    .ready_i(merge_ready),
    .part_o (arith_part)
  );

  // stage 3: 128-bit product and result select
  ckd_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(arith_valid),
    .ready_o(merge_ready),
    .part_i (arith_part),
    .valid_o(merge_valid),
    .ready_i(pack_ready),
    .res_o  (merge_res)
  );

  // stage 4: wrap, range check, output register
  ckd_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (merge_valid),
    .ready_o      (pack_ready),
    .res_i        (merge_res),
    .valid_o      (out_valid_o),
    .ready_i      (!out_stall_i),
    .stored_bits_o(stored_bits_o),
    .overflowed_o (overflowed_o)
  );

  assign in_stall_o = !front_ready;

  `CKD_ASSERT_NOW(a_stall_only_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled while output not blocked")
  `CKD_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, in_valid_i && !in_stall_o, front_valid, "accepted item not held in input stage")

endmodule

FILE: src/ckd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked arithmetic unit: input stage
// Converts both operands to sign-magnitude form and registers the item.
// ----------------------------------------------------------------------------
module ckd_front import ckd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [1:0]       opcode_i,
  input  logic [DataW-1:0] left_bits_i,
  input  logic             left_signed_i,
  input  logic [DataW-1:0] right_bits_i,
  input  logic             right_signed_i,
  input  logic [1:0]       target_width_code_i,
  input  logic             target_signed_i,
  output logic             valid_o,
  input  logic             ready_i,
  output smop_t            op_o
);

  logic             valid_q;
  smop_t            op_q;
  smop_t            op_d;
  logic             l_neg;
  logic             r_neg;
  logic [DataW-1:0] r_mag;

  always_comb begin
    l_neg      = left_signed_i & left_bits_i[DataW-1];
    r_neg      = right_signed_i & right_bits_i[DataW-1];
    r_mag      = r_neg ? ('0 - right_bits_i) : right_bits_i;
    op_d.op    = op_e'(opcode_i);
    op_d.a_neg = l_neg;
    op_d.a_mag = l_neg ? ('0 - left_bits_i) : left_bits_i;
    op_d.b_mag = r_mag;
    // subtract adds the negated right operand; zero keeps its sign
    op_d.b_neg = r_neg ^ ((op_e'(opcode_i) == OP_SUB) && (r_mag != '0));
    op_d.wcode = wcode_e'(target_width_code_i);
    op_d.tsig  = target_signed_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      op_q <= op_d;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;

endmodule

FILE: src/ckd_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked arithmetic unit: arithmetic stage
// Sign-magnitude add/subtract and the four 32x32 partial products.
// ----------------------------------------------------------------------------
module ckd_arith import ckd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  smop_t op_i,
  output logic  valid_o,
  input  logic  ready_i,
  output part_t part_o
);

  logic             valid_q;
  part_t            part_q;
  part_t            part_d;
  logic [DataW:0]   sum;
  logic [DataW:0]   dif_ab;
  logic [DataW-1:0] dif_ba;
  logic [HalfW-1:0] al;
  logic [HalfW-1:0] ah;
  logic [HalfW-1:0] bl;
  logic [HalfW-1:0] bh;

  always_comb begin
    sum    = {1'b0, op_i.a_mag} + {1'b0, op_i.b_mag};
    dif_ab = {1'b0, op_i.a_mag} - {1'b0, op_i.b_mag};
    dif_ba = op_i.b_mag - op_i.a_mag;
    al     = op_i.a_mag[HalfW-1:0];
    ah     = op_i.a_mag[DataW-1:HalfW];
    bl     = op_i.b_mag[HalfW-1:0];
    bh     = op_i.b_mag[DataW-1:HalfW];

    part_d.op = op_i.op;
    part_d.sum_big = 1'b0;
    if (op_i.a_neg == op_i.b_neg) begin
      part_d.sum_mag = sum[DataW-1:0];
      part_d.sum_big = sum[DataW];
      part_d.sum_neg = op_i.a_neg;
    end else if (!dif_ab[DataW]) begin
      part_d.sum_mag = dif_ab[DataW-1:0];
      part_d.sum_neg = op_i.a_neg;
    end else begin
      part_d.sum_mag = dif_ba;
      part_d.sum_neg = op_i.b_neg;
    end
    // exact zero is never negative
    if ((part_d.sum_mag == '0) && !part_d.sum_big) begin
      part_d.sum_neg = 1'b0;
    end

    part_d.pp_ll    = DataW'(al) * DataW'(bl);
    part_d.pp_lh    = DataW'(al) * DataW'(bh);
    part_d.pp_hl    = DataW'(ah) * DataW'(bl);
    part_d.pp_hh    = DataW'(ah) * DataW'(bh);
    part_d.prod_neg = op_i.a_neg ^ op_i.b_neg;
    part_d.wcode    = op_i.wcode;
    part_d.tsig     = op_i.tsig;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      part_q <= part_d;
    end
  end

  assign valid_o = valid_q;
  assign part_o  = part_q;

endmodule

FILE: src/ckd_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked arithmetic unit: merge stage
// Sums the partial products into a 128-bit magnitude and picks the result.
// ----------------------------------------------------------------------------
module ckd_merge import ckd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  part_t part_i,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  res_o
);

  logic             valid_q;
  res_t             res_q;
  res_t             res_d;
  logic [HalfW+1:0] mid;
  logic [DataW-1:0] hi;
  logic [DataW-1:0] pmag;

  always_comb begin
    mid  = (HalfW+2)'(part_i.pp_ll[DataW-1:HalfW])
         + (HalfW+2)'(part_i.pp_lh[HalfW-1:0])
         + (HalfW+2)'(part_i.pp_hl[HalfW-1:0]);
    hi   = part_i.pp_hh
         + DataW'(part_i.pp_lh[DataW-1:HalfW])
         + DataW'(part_i.pp_hl[DataW-1:HalfW])
         + DataW'(mid[HalfW+1:HalfW]);
    pmag = {mid[HalfW-1:0], part_i.pp_ll[HalfW-1:0]};

    res_d.wcode = part_i.wcode;
    res_d.tsig  = part_i.tsig;
    res_d.nop   = 1'b0;
    unique case (part_i.op)
      OP_ADD, OP_SUB: begin
        res_d.mag = part_i.sum_mag;
        res_d.big = part_i.sum_big;
        res_d.neg = part_i.sum_neg;
      end
      OP_MUL: begin
        res_d.mag = pmag;
        res_d.big = hi != '0;
        res_d.neg = part_i.prod_neg && ((pmag != '0) || (hi != '0));
      end
      default: begin
        res_d.nop = 1'b1;
        res_d.mag = '0;
        res_d.big = 1'b0;
        res_d.neg = 1'b0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: src/ckd_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked arithmetic unit: output stage
// Wraps the exact result to the target width and flags overflow.
// ----------------------------------------------------------------------------
`include "checked_add_sub_mul_overflow_unit_macros.svh"

module ckd_pack import ckd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  res_t             res_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [DataW-1:0] stored_bits_o,
  output logic             overflowed_o
);

  logic             valid_q;
  logic [DataW-1:0] bits_q;
  logic [DataW-1:0] bits_d;
  logic             ovf_q;
  logic             ovf_d;
  logic [DataW-1:0] mask;
  logic [DataW-1:0] half;
  logic [DataW-1:0] wrap;
  logic             ovf;

  always_comb begin
    unique case (res_i.wcode)
      WC_8: begin
        mask = DataW'(8'hFF);
        half = DataW'(8'h80);
      end
      WC_16: begin
        mask = DataW'(16'hFFFF);
        half = DataW'(16'h8000);
      end
      WC_32: begin
        mask = DataW'(32'hFFFF_FFFF);
        half = DataW'(32'h8000_0000);
      end
      default: begin
        mask = '1;
        half = {1'b1, {(DataW-1){1'b0}}};
      end
    endcase

    if (res_i.big) begin
      ovf = 1'b1;
    end else if (res_i.neg) begin
      ovf = res_i.tsig ? (res_i.mag > half) : (res_i.mag != '0);
    end else begin
      ovf = res_i.mag > (res_i.tsig ? (mask >> 1) : mask);
    end

    wrap   = res_i.neg ? ('0 - res_i.mag) : res_i.mag;
    bits_d = res_i.nop ? '0 : (wrap & mask);
    ovf_d  = !res_i.nop && ovf;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      bits_q <= bits_d;
      ovf_q  <= ovf_d;
    end
  end

  assign valid_o       = valid_q;
  assign stored_bits_o = bits_q;
  assign overflowed_o  = ovf_q;

  `CKD_ASSERT_NEXT(a_nop_clean, clk_i, rst_ni, valid_i && ready_o && res_i.nop, (bits_q == '0) && !ovf_q, "unused opcode gave a nonzero result")
  `CKD_ASSERT_NEXT(a_zero_fits, clk_i, rst_ni, valid_i && ready_o && !res_i.big && (res_i.mag == '0), !ovf_q && (bits_q == '0), "exact zero flagged or nonzero")
  `CKD_ASSERT_NEXT(a_byte_upper, clk_i, rst_ni, valid_i && ready_o && (res_i.wcode == WC_8), bits_q[DataW-1:8] == '0, "bits above a byte target not cleared")

endmodule
